@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/psfp_pkg.sv @@
// Package with frame constants, status codes and the result struct of the frame parser.
package psfp_pkg;

	localparam logic [7:0] HDR_BYTE0 = 8'h16;
	localparam logic [7:0] HDR_BYTE1 = 8'h11;
	localparam logic [7:0] HDR_BYTE2 = 8'h0B;

	localparam int unsigned POS_W = 5;
	localparam logic [POS_W-1:0] HDR_LEN      = 5'd3;
	localparam logic [POS_W-1:0] DUTY_HI_POS  = 5'd5;
	localparam logic [POS_W-1:0] DUTY_LO_POS  = 5'd6;
	localparam logic [POS_W-1:0] FRAME_LAST_POS = 5'd19;

	localparam logic [1:0] STATUS_GOOD     = 2'd0;
	localparam logic [1:0] STATUS_HDR_ERR  = 2'd1;
	localparam logic [1:0] STATUS_CSUM_ERR = 2'd2;

	localparam logic [15:0] PM_SAT_WIDE = 16'd1000;
	localparam logic [9:0]  PM_SAT      = 10'd1000;

	typedef struct packed {
		logic        emit;
		logic [1:0]  status;
		logic [15:0] duty;
		logic [9:0]  pm;
	} psfp_result_t;

endpackage

@@ hw/rtl/psfp_frame_check.sv @@
// Frame tracker: byte position, running sum, duty bytes and the per-byte verdict.
module psfp_frame_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  logic [7:0]           byte_s1,
	input  logic                 advance,
	output psfp_pkg::psfp_result_t result
);
	import psfp_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [7:0]       duty_hi_q;
	logic [7:0]       duty_lo_q;

	logic [7:0]  new_sum;
	logic [7:0]  hdr_expect;
	logic [15:0] raw;
	logic        restart;

	always_comb begin
		new_sum = sum_q + byte_s1;
		raw     = {duty_hi_q, duty_lo_q};
		case (pos_q[1:0])
			2'd0:    hdr_expect = HDR_BYTE0;
			2'd1:    hdr_expect = HDR_BYTE1;
			default: hdr_expect = HDR_BYTE2;
		endcase
		result.emit   = 1'b0;
		result.status = STATUS_GOOD;
		result.duty   = '0;
		result.pm     = '0;
		restart       = 1'b0;
		if (pos_q < HDR_LEN) begin
			if (byte_s1 != hdr_expect) begin
				result.emit   = valid_s1;
				result.status = STATUS_HDR_ERR;
				restart       = 1'b1;
			end
		end else if (pos_q >= FRAME_LAST_POS) begin
			// checksum byte closes the frame either way
			result.emit = valid_s1;
			restart     = 1'b1;
			if (new_sum != 8'd0) begin
				result.status = STATUS_CSUM_ERR;
			end else begin
				result.duty = raw;
				result.pm   = (raw > PM_SAT_WIDE) ? PM_SAT : raw[9:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			duty_hi_q <= '0;
			duty_lo_q <= '0;
		end else if (advance) begin
			if (restart) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_q + 5'd1;
				sum_q <= new_sum;
			end
			if (pos_q == DUTY_HI_POS) duty_hi_q <= byte_s1;
			if (pos_q == DUTY_LO_POS) duty_lo_q <= byte_s1;
		end
	end

endmodule

@@ hw/rtl/psfp_out_reg.sv @@
// Result register that holds a verdict until the receiver takes it.
module psfp_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  psfp_pkg::psfp_result_t result,
	input  logic                  res_ready,
	output logic                  res_valid,
	output logic [1:0]            frame_status,
	output logic [15:0]           duty_word,
	output logic [9:0]            pm_half_units
);
	import psfp_pkg::*;

	logic        valid_q;
	logic [1:0]  status_q;
	logic [15:0] duty_q;
	logic [9:0]  pm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= result.status;
			duty_q   <= result.duty;
			pm_q     <= result.pm;
		end
	end

	assign res_valid     = valid_q;
	assign frame_status  = status_q;
	assign duty_word     = duty_q;
	assign pm_half_units = pm_q;

endmodule

@@ hw/rtl/particle_sensor_frame_parser.sv @@
// Top level of the particle sensor serial frame parser.
// Usage:
//   rx channel  (rx_valid / rx_ready / rx_byte): one received serial byte per request.
//   res channel (res_valid / res_ready / frame_status, duty_word, pm_half_units):
//     one verdict per frame, or one per rejected header byte.
//   A frame is 20 bytes: header 0x16 0x11 0x0B, sixteen payload bytes, and a checksum
//   byte that makes the 8-bit sum of the frame zero. Payload bytes give no result.
//   On a good frame duty_word is bytes 5 and 6 big-endian and pm_half_units is
//   duty_word saturated at 1000; both read zero on a header or checksum error.
//   A mismatching header byte is dropped, not taken as the start of a new frame.
// Timing:
//   Throughput is one byte per cycle while no result waits on res_ready. A byte
//   accepted sits in the input register and is judged there; its result loads the
//   result register when the byte advances, which raises res_valid.
// Stall:
//   While res_ready is low, the result register holds. Payload bytes keep flowing;
//   a byte that closes a frame or breaks a header waits in the input register, and
//   rx_ready drops until the pending result is taken.
// Reset:
//   arst_n clears position, running sum, duty bytes and both valid flags at once.
module particle_sensor_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  frame_status,
	output logic [15:0] duty_word,
	output logic [9:0]  pm_half_units
);
	import psfp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         advance;
	psfp_result_t result;

	// Advance the held byte unless it has a result, the result register is full and res_ready is low.
	assign advance  = valid_s1 && (!result.emit || !res_valid || res_ready);
	assign rx_ready = !valid_s1 || advance;

	// Input register: hold the request until the tracker consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	psfp_frame_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.advance  (advance),
		.result   (result)
	);

	psfp_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && result.emit),
		.result        (result),
		.res_ready     (res_ready),
		.res_valid     (res_valid),
		.frame_status  (frame_status),
		.duty_word     (duty_word),
		.pm_half_units (pm_half_units)
	);

endmodule

@@ hw/rtl/psfp_checker.sv @@
// Port-level checker for the frame parser, bound to the top level.
`include "assert_macros.svh"

module psfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  frame_status,
	input logic [15:0] duty_word,
	input logic [9:0]  pm_half_units
);
	import psfp_pkg::*;

	logic        stalled;
	logic        good_res;
	logic        err_res;
	logic        data_zero;
	logic        status_known;
	logic [27:0] res_fields;
	logic [9:0]  pm_expect;

	assign stalled      = res_valid && !res_ready;
	assign good_res     = res_valid && (frame_status == STATUS_GOOD);
	assign err_res      = res_valid && (frame_status != STATUS_GOOD);
	assign data_zero    = (duty_word == 16'd0) && (pm_half_units == 10'd0);
	assign status_known = (frame_status == STATUS_GOOD) || (frame_status == STATUS_HDR_ERR)
		|| (frame_status == STATUS_CSUM_ERR);
	assign res_fields   = {frame_status, duty_word, pm_half_units};
	assign pm_expect    = (duty_word > PM_SAT_WIDE) ? PM_SAT : duty_word[9:0];

	`ASSERT_CLK(a_res_hold, clk, arst_n, stalled |=> res_valid, "result dropped while stalled")
	`ASSERT_CLK(a_res_stable, clk, arst_n, stalled |=> $stable(res_fields), "result changed in stall")
	`ASSERT_CLK(a_err_zero, clk, arst_n, err_res |-> data_zero, "error result carries data")
	`ASSERT_CLK(a_pm_sat, clk, arst_n, good_res |-> pm_half_units == pm_expect, "pm does not follow duty")
	`ASSERT_CLK(a_status_code, clk, arst_n, res_valid |-> status_known, "undefined status code")

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (.*);
